[rtl/sfdr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfdr_pkg
// Shared types and constants for the SFD search and bit realign block.
// ----------------------------------------------------------------------------
package sfdr_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  localparam logic [7:0] SFD_RESET       = 8'hA7;
  localparam logic [2:0] PREAMBLE_RESET  = 3'd4;
  localparam logic [3:0] THRESH_RESET    = 4'd7;
  localparam logic [6:0] PHR_MASK        = 7'h7F;
  localparam logic [6:0] FCS_BYTES       = 7'd2;

  typedef enum logic [1:0] {
    CFG_SFD_VALUE       = 2'd0,
    CFG_PREAMBLE_OCTETS = 2'd1,
    CFG_MATCH_THRESHOLD = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_DONE    = 3'd1,
    KIND_NO_SFD  = 3'd2,
    KIND_SHORT   = 3'd3,
    KIND_BAD_PHR = 3'd4,
    KIND_TRUNC   = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_SEARCH  = 4'b0001,
    ST_LOCKED  = 4'b0010,
    ST_NO_SFD  = 4'b0100,
    ST_BAD_PHR = 4'b1000
  } sfd_st_e;

  typedef struct packed {
    logic [7:0] sfd_value;
    logic [2:0] preamble_octets;
    logic [3:0] match_threshold;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    logic [6:0] payload_length;
    logic [1:0] bit_shift;
    logic       end_of_frame;
  } result_t;

endpackage
`default_nettype wire

[rtl/sfd_search_and_bit_realign.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_search_and_bit_realign
// Finds the SFD in a raw receive byte stream, realigns the frame bytes and
// reports a status beat per frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one raw FIFO byte per beat; tuser marks the first byte of a frame,
//   tlast the final byte. m_axis: realigned payload beats (kind payload), then
//   one status beat with tlast high closing the frame. The FCS is dropped.
//   cfg_*: write sfd_value, preamble_octets, match_threshold while idle.
// Path: a byte taken lands in the input register, is stepped into the core once
//   the queue has room, and its results show on m_axis from the output queue.
// Throughput: 1 byte per cycle while each byte yields at most one result and
//   m_axis_tready stays high; the final byte of a frame may yield two, which the
//   4-entry output queue drains one per cycle while m_axis_tready is high. The
//   input register steps whenever the queue holds 2 or fewer.
// Reset: clears the frame state, empties the queue and loads the register
//   defaults (SFD 0xA7, 4 preamble octets, threshold 7).
// Stall: when m_axis_tready is low the queue fills, the input register holds
//   its byte and s_axis_tready drops; no beat is lost.
// ----------------------------------------------------------------------------
module sfd_search_and_bit_realign
  import sfdr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] frame_first
  input  wire logic        s_axis_tlast,   // frame_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] out_byte, [14:8] payload_length,
                                           // [16:15] bit_shift, [23:17] zero
  output logic [2:0]       m_axis_tuser,   // [2:0] kind
  output logic             m_axis_tlast    // end_of_frame
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sfd_value       <= SFD_RESET;
      cfg_q.preamble_octets <= PREAMBLE_RESET;
      cfg_q.match_threshold <= THRESH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SFD_VALUE:       cfg_q.sfd_value       <= cfg_data_i;
        CFG_PREAMBLE_OCTETS: cfg_q.preamble_octets <= cfg_data_i[2:0];
        CFG_MATCH_THRESHOLD: cfg_q.match_threshold <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_first_q, in_last_q;
  logic       advance;
  logic [CNT_W-1:0] count_q;

  assign advance       = in_v_q && (count_q <= CNT_W'(FIFO_DEPTH - 2));
  assign s_axis_tready = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser;
      in_last_q  <= s_axis_tlast;
    end
  end

  logic    pay_v, stat_v;
  result_t pay, stat;

  sfdr_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .step_i        (advance),
    .rx_byte_i     (in_byte_q),
    .frame_first_i (in_first_q),
    .frame_last_i  (in_last_q),
    .pay_valid_o   (pay_v),
    .pay_o         (pay),
    .stat_valid_o  (stat_v),
    .stat_o        (stat)
  );

  // result queue
  result_t          mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] n_push, count_d;
  logic             pop;
  result_t          head;

  assign n_push  = advance ? (CNT_W'(pay_v) + CNT_W'(stat_v)) : '0;
  assign pop     = m_axis_tvalid && m_axis_tready;
  assign count_d = count_q + n_push - CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (pay_v) begin
        mem[wr_q] <= pay;
        if (stat_v) begin
          mem[wr_q + PTR_W'(1)] <= stat;
        end
      end else if (stat_v) begin
        mem[wr_q] <= stat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + n_push[PTR_W-1:0];
      rd_q    <= rd_q + PTR_W'(pop);
      count_q <= count_d;
    end
  end

  assign head          = mem[rd_q];
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = {7'd0, head.bit_shift, head.payload_length, head.out_byte};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.end_of_frame;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");
  a_room_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> (count_q + n_push <= CNT_W'(FIFO_DEPTH)))
    else $error("step without room for its results");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready && !advance) |=> $stable(count_q))
    else $error("queue level moved while stalled");
  a_eof_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (head.kind != KIND_PAYLOAD))
    else $error("end of frame on a payload beat");
`endif

endmodule
`default_nettype wire

[rtl/sfdr_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfdr_core
// Per-frame state and the one-beat step: SFD check, realign, status.
// ----------------------------------------------------------------------------
module sfdr_core
  import sfdr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_t    cfg_i,
  input  wire logic    step_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic    frame_first_i,
  input  wire logic    frame_last_i,
  output logic         pay_valid_o,
  output result_t      pay_o,
  output logic         stat_valid_o,
  output result_t      stat_o
);

  logic [7:0] prev_q, prev_d, prev_e;
  logic [7:0] idx_q, idx_d, idx_e;
  logic [1:0] off_q, off_d, off_e;
  sfd_st_e    st_q, st_d, st_e;
  logic       phr_q, phr_d, phr_e;
  logic [6:0] len_q, len_d, len_e;
  logic [6:0] cnt_q, cnt_d, cnt_e;

  logic [2:0] s_pos;
  logic [7:0] s_plus1, s_plus2;
  logic [7:0] w1, w2, realign;
  logic [3:0] c0, c1, c2;
  logic [6:0] phr_val;
  kind_e      stat_kind;

  assign w1 = {prev_e[6:0], rx_byte_i[7]};
  assign w2 = {prev_e[5:0], rx_byte_i[7:6]};

  always_comb begin
    // frame_first wipes the frame state before the byte is looked at
    prev_e = frame_first_i ? 8'd0 : prev_q;
    idx_e  = frame_first_i ? 8'd0 : idx_q;
    off_e  = frame_first_i ? 2'd0 : off_q;
    st_e   = frame_first_i ? ST_SEARCH : st_q;
    phr_e  = frame_first_i ? 1'b0 : phr_q;
    len_e  = frame_first_i ? 7'd0 : len_q;
    cnt_e  = frame_first_i ? 7'd0 : cnt_q;
  end

  always_comb begin
    s_pos   = (cfg_i.preamble_octets == 3'd0) ? 3'd0 : cfg_i.preamble_octets - 3'd1;
    s_plus1 = {5'd0, s_pos} + 8'd1;
    s_plus2 = {5'd0, s_pos} + 8'd2;
    c0 = 4'($countones(~(cfg_i.sfd_value ^ prev_e)));
    c1 = 4'($countones(~(cfg_i.sfd_value ^ w1)));
    c2 = 4'($countones(~(cfg_i.sfd_value ^ w2)));
    case (off_e)
      2'd1:    realign = w1;
      2'd2:    realign = w2;
      default: realign = prev_e;
    endcase
    phr_val = realign[6:0] & PHR_MASK;
  end

  always_comb begin
    off_d = off_e;
    st_d  = st_e;
    phr_d = phr_e;
    len_d = len_e;
    cnt_d = cnt_e;
    pay_valid_o = 1'b0;

    if (st_e == ST_SEARCH && idx_e >= s_plus1) begin
      st_d = ST_LOCKED;
      if (c1 >= cfg_i.match_threshold) begin
        off_d = 2'd1;
      end else if (c2 >= cfg_i.match_threshold) begin
        off_d = 2'd2;
      end else if (c0 >= cfg_i.match_threshold) begin
        off_d = 2'd0;
      end else begin
        off_d = 2'd0;
        st_d  = ST_NO_SFD;
      end
    end else if (st_e == ST_LOCKED && idx_e >= s_plus2) begin
      if (!phr_e) begin
        phr_d = 1'b1;
        if (phr_val < FCS_BYTES) begin
          len_d = 7'd0;
          st_d  = ST_BAD_PHR;
        end else begin
          len_d = phr_val - FCS_BYTES;
        end
      end else if (cnt_e < len_e) begin
        cnt_d = cnt_e + 7'd1;
        pay_valid_o = 1'b1;
      end
    end

    prev_d = rx_byte_i;
    idx_d  = (idx_e == 8'hFF) ? idx_e : idx_e + 8'd1;

    case (st_d)
      ST_SEARCH:  stat_kind = KIND_SHORT;
      ST_NO_SFD:  stat_kind = KIND_NO_SFD;
      ST_BAD_PHR: stat_kind = KIND_BAD_PHR;
      default:    stat_kind = (phr_d && cnt_d == len_d) ? KIND_DONE : KIND_TRUNC;
    endcase
    stat_valid_o = frame_last_i;

    pay_o.out_byte       = realign;
    pay_o.kind           = KIND_PAYLOAD;
    pay_o.payload_length = len_d;
    pay_o.bit_shift      = off_d;
    pay_o.end_of_frame   = 1'b0;

    stat_o.out_byte       = 8'd0;
    stat_o.kind           = stat_kind;
    stat_o.payload_length = len_d;
    stat_o.bit_shift      = off_d;
    stat_o.end_of_frame   = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 8'd0;
      idx_q  <= 8'd0;
      off_q  <= 2'd0;
      st_q   <= ST_SEARCH;
      phr_q  <= 1'b0;
      len_q  <= 7'd0;
      cnt_q  <= 7'd0;
    end else if (step_i) begin
      if (frame_last_i) begin
        // status closes the frame; next byte starts fresh
        prev_q <= 8'd0;
        idx_q  <= 8'd0;
        off_q  <= 2'd0;
        st_q   <= ST_SEARCH;
        phr_q  <= 1'b0;
        len_q  <= 7'd0;
        cnt_q  <= 7'd0;
      end else begin
        prev_q <= prev_d;
        idx_q  <= idx_d;
        off_q  <= off_d;
        st_q   <= st_d;
        phr_q  <= phr_d;
        len_q  <= len_d;
        cnt_q  <= cnt_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= len_q)
    else $error("payload count passed the PHR length");
  a_pay_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && pay_valid_o) |-> (st_e == ST_LOCKED && phr_e))
    else $error("payload beat without lock and PHR");
  a_bad_phr_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_BAD_PHR) |-> (len_q == 7'd0 && phr_q))
    else $error("bad PHR state with nonzero length");
`endif

endmodule
`default_nettype wire

[sim/sfdr_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdr_frame_checker
// Watches the config port and both streams of the SFD search and realign
// block, predicts the realigned bytes and frame status of every accepted
// input beat, and compares each output beat field by field, in order.
// ----------------------------------------------------------------------------
module sfdr_frame_checker
  import sfdr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] frame_first
  input  wire logic        s_axis_tlast,   // frame_last
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [23:0] m_axis_tdata,   // [7:0] out_byte, [14:8] payload_length,
                                           // [16:15] bit_shift, [23:17] zero
  input  wire logic [2:0]  m_axis_tuser,   // [2:0] kind
  input  wire logic        m_axis_tlast,   // end_of_frame
  output int               fail_count,
  output int               pending_beats
);

  logic [7:0] cfg_sfd;
  logic [2:0] cfg_pre;
  logic [3:0] cfg_thr;

  logic [7:0] prev_byte;
  logic [7:0] byte_idx;
  logic [1:0] offset;
  sfd_st_e    sfd_st;
  logic       phr_seen;
  logic [6:0] phr_len;
  logic [6:0] sent_count;

  result_t    expected_q[$];

  task automatic clear_frame();
    prev_byte  = '0;
    byte_idx   = '0;
    offset     = '0;
    sfd_st     = ST_SEARCH;
    phr_seen   = 1'b0;
    phr_len    = '0;
    sent_count = '0;
  endtask

  task automatic queue_result(input logic [7:0] octet, input kind_e kind, input logic eof);
    result_t res;
    res.out_byte       = octet;
    res.kind           = kind;
    res.payload_length = phr_len;
    res.bit_shift      = offset;
    res.end_of_frame   = eof;
    expected_q.push_back(res);
  endtask

  task automatic step_frame(input logic [7:0] cur, input logic first, input logic last);
    logic [15:0] pair;
    logic [7:0]  win1, win2, realigned;
    int          sfd_pos;
    kind_e       status_kind;
    if (first) clear_frame();
    sfd_pos = (cfg_pre == 0) ? 0 : cfg_pre - 1;
    pair    = {prev_byte, cur};
    win1    = pair[14:7];
    win2    = pair[13:6];
    if (sfd_st == ST_SEARCH && byte_idx >= sfd_pos + 1) begin
      // priority: one-bit slip, then two-bit, then aligned
      sfd_st = ST_LOCKED;
      if ($countones(~(cfg_sfd ^ win1)) >= cfg_thr) begin
        offset = 2'd1;
      end else if ($countones(~(cfg_sfd ^ win2)) >= cfg_thr) begin
        offset = 2'd2;
      end else if ($countones(~(cfg_sfd ^ prev_byte)) >= cfg_thr) begin
        offset = 2'd0;
      end else begin
        offset = 2'd0;
        sfd_st = ST_NO_SFD;
      end
    end else if (sfd_st == ST_LOCKED && byte_idx >= sfd_pos + 2) begin
      realigned = 8'(pair >> (8 - offset));
      if (!phr_seen) begin
        phr_seen = 1'b1;
        if ((realigned[6:0] & PHR_MASK) < FCS_BYTES) begin
          phr_len = '0;
          sfd_st  = ST_BAD_PHR;
        end else begin
          phr_len = (realigned[6:0] & PHR_MASK) - FCS_BYTES;
        end
      end else if (sent_count < phr_len) begin
        sent_count++;
        queue_result(realigned, KIND_PAYLOAD, 1'b0);
      end
    end
    prev_byte = cur;
    if (byte_idx != 8'hFF) byte_idx++;
    if (last) begin
      case (sfd_st)
        ST_SEARCH:  status_kind = KIND_SHORT;
        ST_NO_SFD:  status_kind = KIND_NO_SFD;
        ST_BAD_PHR: status_kind = KIND_BAD_PHR;
        default:    status_kind = (phr_seen && sent_count == phr_len) ? KIND_DONE : KIND_TRUNC;
      endcase
      queue_result(8'h00, status_kind, 1'b1);
      clear_frame();
    end
  endtask

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("ERROR %0t ns: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
    fail_count++;
  endtask

  task automatic check_result();
    result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result beat with nothing pending, out_byte", m_axis_tdata[7:0], 16'h0);
    end else begin
      want = expected_q.pop_front();
      if (m_axis_tdata[7:0] !== want.out_byte)
        report_mismatch("out_byte", m_axis_tdata[7:0], want.out_byte);
      if (m_axis_tuser[2:0] !== want.kind)
        report_mismatch("kind", m_axis_tuser[2:0], want.kind);
      if (m_axis_tdata[14:8] !== want.payload_length)
        report_mismatch("payload_length", m_axis_tdata[14:8], want.payload_length);
      if (m_axis_tdata[16:15] !== want.bit_shift)
        report_mismatch("bit_shift", m_axis_tdata[16:15], want.bit_shift);
      if (m_axis_tdata[23:17] !== 7'h0)
        report_mismatch("tdata spare bits", m_axis_tdata[23:17], 16'h0);
      if (m_axis_tlast !== want.end_of_frame)
        report_mismatch("end_of_frame", m_axis_tlast, want.end_of_frame);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sfd = SFD_RESET;
      cfg_pre = PREAMBLE_RESET;
      cfg_thr = THRESH_RESET;
      clear_frame();
      expected_q.delete();
      fail_count    = 0;
      pending_beats = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SFD_VALUE:       cfg_sfd = cfg_data_i;
          CFG_PREAMBLE_OCTETS: cfg_pre = cfg_data_i[2:0];
          CFG_MATCH_THRESHOLD: cfg_thr = cfg_data_i[3:0];
          default: ;
        endcase
      end
      // an input beat never yields a result on the same edge, so order is free
      if (s_axis_tvalid && s_axis_tready) step_frame(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_result();
      pending_beats = expected_q.size();
    end
  end

endmodule

[sim/sfd_search_and_bit_realign_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_search_and_bit_realign_tb
// Feeds raw receive frames to the SFD search and realign block: one
// directed frame for each status, then random frames (clean, bit-slipped,
// near-miss SFD, cut short, bad PHR, unmarked, aborted, noise) over several
// register settings and idle/stall mixes. A checker module does the scoring.
// ----------------------------------------------------------------------------
module sfd_search_and_bit_realign_tb;
  import sfdr_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        s_axis_tuser;   // [0] frame_first
  logic        s_axis_tlast;   // frame_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] out_byte, [14:8] payload_length, [16:15] bit_shift
  logic [2:0]  m_axis_tuser;   // [2:0] kind
  logic        m_axis_tlast;   // end_of_frame

  int fail_count;
  int pending_beats;

  int         src_idle_pct   = 0;
  int         sink_stall_pct = 0;
  int         hold_cycles    = 0;
  int         sent_items     = 0;
  int         pre_oct        = PREAMBLE_RESET;
  logic [7:0] sfd_cur        = SFD_RESET;

  sfd_search_and_bit_realign uut (.*);

  sfdr_frame_checker u_checker (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_beat(input logic [7:0] octet, input logic first, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= octet;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    sent_items++;
  endtask

  task automatic send_frame(input int shift, input logic [7:0] sfd_byte,
                            input logic [7:0] phr, input int n_pay, input int n_tail,
                            input int cut, input bit mark_first, input bit mark_last);
    logic [7:0] octets[$];
    logic [7:0] carry, spill;
    int         n_beats;
    repeat (pre_oct - 1)
      octets.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h00);
    octets.push_back(sfd_byte);
    octets.push_back(phr);
    repeat (n_pay + 2 + n_tail) octets.push_back(8'($urandom_range(255)));
    // on the wire the frame bits trail `shift` junk bits, MSB first
    carry = 8'($urandom_range(255));
    foreach (octets[i]) begin
      spill     = carry << (8 - shift);
      carry     = octets[i];
      octets[i] = spill | (octets[i] >> shift);
    end
    n_beats = (cut > 0 && cut < octets.size()) ? cut : octets.size();
    for (int i = 0; i < n_beats; i++)
      send_beat(octets[i], mark_first && i == 0, mark_last && i == n_beats - 1);
  endtask

  task automatic send_random_frame();
    int         pick, shift, n_pay, n_tail, full_len, cut, sfd_pos, n_noise;
    logic [7:0] sfd_byte, phr;
    bit         mark_first, mark_last;
    pick       = $urandom_range(99);
    sfd_pos    = pre_oct - 1;
    shift      = $urandom_range(2);
    sfd_byte   = sfd_cur;
    n_pay      = ($urandom_range(29) == 0) ? $urandom_range(125) : $urandom_range(12);
    n_tail     = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
    phr        = {1'($urandom_range(1)), 7'(n_pay + 2)};
    full_len   = sfd_pos + 4 + n_pay + n_tail;
    cut        = 0;
    mark_first = 1'b1;
    mark_last  = 1'b1;
    if (pick < 60) begin
      // clean frame
    end else if (pick < 68) begin
      repeat ($urandom_range(3, 1)) sfd_byte[$urandom_range(7)] ^= 1'b1;
    end else if (pick < 75) begin
      cut = $urandom_range(full_len - 1, sfd_pos + 2);
    end else if (pick < 80) begin
      cut = $urandom_range(sfd_pos + 1, 1);
    end else if (pick < 86) begin
      phr[6:0] = 7'($urandom_range(1));
    end else if (pick < 91) begin
      mark_first = 1'b0;
    end else if (pick < 96) begin
      mark_last = 1'b0;
    end
    if (pick >= 96) begin
      n_noise = $urandom_range(10, 1);
      repeat (n_noise)
        send_beat(8'($urandom_range(255)), $urandom_range(9) == 0, $urandom_range(4) == 0);
    end else begin
      send_frame(shift, sfd_byte, phr, n_pay, n_tail, cut, mark_first, mark_last);
    end
  endtask

  // quiet the input and let every pending result out before touching config
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    while (pending_beats != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_config(input logic [7:0] sfd, input logic [2:0] pre,
                              input logic [3:0] thr);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SFD_VALUE;
    cfg_data_i <= sfd;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_PREAMBLE_OCTETS;
    cfg_data_i <= {5'b0, pre};
    @(negedge clk_i);
    cfg_idx_i  <= CFG_MATCH_THRESHOLD;
    cfg_data_i <= {4'b0, thr};
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    sfd_cur = sfd;
    pre_oct = pre;
  endtask

  initial begin
    int phase_end;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_SFD_VALUE;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed frames on the reset register values
    send_frame(1, SFD_RESET, 8'h02, 0, 0, 0, 1, 1);   // zero-length payload, done
    send_frame(2, SFD_RESET, 8'hFF, 2, 0, 8, 1, 1);   // longest PHR, cut off
    send_beat(8'hFF, 1'b1, 1'b0);                     // too short
    send_beat(8'h00, 1'b0, 1'b1);
    send_frame(0, SFD_RESET, 8'h81, 0, 0, 6, 1, 1);   // PHR length below FCS
    send_frame(0, ~SFD_RESET, 8'h05, 0, 0, 6, 1, 1);  // SFD fully inverted

    for (int phase = 0; phase < 8; phase++) begin
      drain_block();
      case (phase)
        0: write_config(SFD_RESET, 3'd4, 4'd7);
        1: write_config(8'h00, 3'd1, 4'd8);
        2: write_config(8'hFF, 3'd4, 4'd0);
        3: write_config(8'($urandom_range(255)), 3'd2, 4'd8);
        4: write_config(8'($urandom_range(255)), 3'd3, 4'd5);
        5: write_config(8'h5A, 3'd1, 4'd6);
        6: write_config(8'($urandom_range(255)), 3'd4, 4'd1);
        default: write_config(8'($urandom_range(255)), 3'($urandom_range(4, 1)),
                              4'($urandom_range(8)));
      endcase
      case (phase % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 84; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 84; end
        default: begin src_idle_pct = 18; sink_stall_pct = 18; end
      endcase
      if (phase == 0) begin
        // long receiver hold-off while a long frame keeps coming
        @(posedge clk_i);
        hold_cycles = 200;
        @(negedge clk_i);
        send_frame(0, sfd_cur, {1'b0, 7'd42}, 40, 0, 0, 1, 1);
      end
      phase_end = sent_items + 150;
      while (sent_items < phase_end) send_random_frame();
    end

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    drain_block();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/sfdr_pkg.sv
rtl/sfdr_core.sv
rtl/sfd_search_and_bit_realign.sv
sim/sfdr_frame_checker.sv
sim/sfd_search_and_bit_realign_tb.sv
